// File: rtl/qad_pkg.sv
// Shared widths, register codes, pipeline side-band type and step functions
// for the QUEST attitude pipeline. No dependencies.
`default_nettype none

package qad_pkg;

    // Input sample width and fraction bits of the unit vectors and the output quaternion
    localparam int SAMPLE_WIDTH  = 16;
    localparam int UNIT_FRAC     = 14;
    localparam int OUT_FRAC_BITS = 14;

    // Observation layout: four 3-vectors per item
    localparam int N_VEC  = 4;
    localparam int N_AXIS = 3;
    localparam int V_ACC   = 0;
    localparam int V_GRAV  = 1;
    localparam int V_MAG   = 2;
    localparam int V_NORTH = 3;

    // Configuration port
    localparam int CFG_IDX_W = 1;
    localparam int WEIGHT_W  = 16;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_WEIGHT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAG_WEIGHT   = 1'b1;
    localparam logic [WEIGHT_W-1:0]  WEIGHT_RESET     = 16'd8192;

    // Unit-scaling core
    localparam int UNIT_N    = 4;             // components per core
    localparam int VEC_W     = 72;            // normalizing window
    localparam int SHIFT_N   = 7;             // shift steps 64,32,...,1
    localparam int SHIFT_MAX = 64;
    localparam int UNIT_W    = 30;            // normalized magnitude
    localparam int SQ_W      = 2 * UNIT_W;
    localparam int ACC_W     = 64;            // sum of squares and root state
    localparam int SQRT_N    = 32;            // one root bit per stage
    localparam int ROOT_W    = 32;
    localparam int Q_W       = 16;            // quotient / output field width
    localparam int DIV_N     = Q_W;           // one quotient bit per stage
    localparam int DIV_W     = 48;
    localparam int TAG_W     = 5;
    localparam int CORE_LAT  = 1 + SHIFT_N + 1 + 1 + SQRT_N + 1 + DIV_N;

    // Attitude math widths (signed)
    localparam int U_W  = 16;                 // unit component, 14 fraction bits
    localparam int P_W  = 32;                 // unit x unit
    localparam int T_W  = 49;                 // weight x product
    localparam int B_W  = 22;                 // profile matrix entry
    localparam int B_SHIFT = 28;
    localparam int M_W  = 22;                 // Davenport matrix entry
    localparam int Z_W  = 20;                 // z vector entry
    localparam int C_W  = 46;                 // cofactor
    localparam int C_SPLIT = 23;              // low half width of a cofactor
    localparam int PL_W = 48;                 // partial product
    localparam int W_W  = 72;                 // determinant and numerators

    localparam logic signed [W_W-1:0] DET_MIN = 72'sd4398047;

    typedef struct packed {
        logic             valid;
        logic [TAG_W-1:0] tag;
    } t_side;

    typedef struct packed {
        logic [ACC_W-1:0] x;
        logic [ACC_W-1:0] r;
    } t_sqrt;

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic             hit;
    } t_div;

    // One step of the bit-pair integer square root
    function automatic t_sqrt sqrt_step(input logic [ACC_W-1:0] x,
                                        input logic [ACC_W-1:0] r,
                                        input logic [ACC_W-1:0] one_v);
        t_sqrt            res;
        logic [ACC_W-1:0] t;
        t = r + one_v;
        if (x >= t) begin
            res.x = x - t;
            res.r = (r >> 1) + one_v;
        end else begin
            res.x = x;
            res.r = r >> 1;
        end
        return res;
    endfunction

    // One step of restoring division: try the divisor shifted by amt
    function automatic t_div div_step(input logic [DIV_W-1:0]  rem,
                                      input logic [ROOT_W-1:0] len,
                                      input int                amt);
        t_div             res;
        logic [DIV_W-1:0] d;
        d = DIV_W'(len) << amt;
        res.hit = (rem >= d);
        res.rem = res.hit ? rem - d : rem;
        return res;
    endfunction

endpackage

`default_nettype wire

// File: rtl/qad_unit_core.sv
// Unit-length scaling pipeline: normalize, integer square root, divide.
// Four magnitudes in, four rounded quotients out. Depends on qad_pkg.
`default_nettype none

module qad_unit_core
    import qad_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  t_side                         i_side,
    input  logic [UNIT_N-1:0][VEC_W-1:0]  i_mag,
    output t_side                         o_side,
    output logic [UNIT_N-1:0][Q_W-1:0]    o_q
);

    logic [VEC_W-1:0] n_max01;
    logic [VEC_W-1:0] n_max23;
    logic [VEC_W-1:0] n_top;

    logic             r_valid [CORE_LAT];
    logic             r_zero  [CORE_LAT];
    logic [TAG_W-1:0] r_tag   [CORE_LAT];

    logic [VEC_W-1:0]              r_top [SHIFT_N];
    logic [UNIT_N-1:0][VEC_W-1:0]  r_sh  [SHIFT_N+1];
    logic [UNIT_N-1:0][UNIT_W-1:0] r_w;
    logic [UNIT_N-1:0][SQ_W-1:0]   r_sq;
    logic [ACC_W-1:0]              r_sx  [SQRT_N];
    logic [ACC_W-1:0]              r_sr  [SQRT_N+1];
    logic [UNIT_N-1:0][UNIT_W-1:0] r_sw  [SQRT_N+1];
    logic [UNIT_N-1:0][DIV_W-1:0]  r_rem [DIV_N];
    logic [ROOT_W-1:0]             r_dlen [DIV_N];
    logic [UNIT_N-1:0][Q_W-1:0]    r_q   [DIV_N+1];

    t_sqrt n_st [SQRT_N];
    t_div  n_dv [DIV_N][UNIT_N];

    // Largest magnitude through a two-level compare tree
    always_comb begin
        n_max01 = (i_mag[0] > i_mag[1]) ? i_mag[0] : i_mag[1];
        n_max23 = (i_mag[2] > i_mag[3]) ? i_mag[2] : i_mag[3];
        n_top   = (n_max01 > n_max23) ? n_max01 : n_max23;
    end

    always_comb begin
        for (int s = 0; s < SQRT_N; s++) begin
            n_st[s] = sqrt_step(r_sx[s], r_sr[s], ACC_W'(1) << (ACC_W - 2 - 2 * s));
        end
        for (int k = 0; k < DIV_N; k++) begin
            for (int c = 0; c < UNIT_N; c++) begin
                n_dv[k][c] = div_step(r_rem[k][c], r_dlen[k], Q_W - 1 - k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CORE_LAT; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_valid[0] <= i_side.valid;
            for (int k = 1; k < CORE_LAT; k++) begin
                r_valid[k] <= r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (n_top == '0);
            r_tag[0]  <= i_side.tag;
            for (int k = 1; k < CORE_LAT; k++) begin
                r_zero[k] <= r_zero[k-1];
                r_tag[k]  <= r_tag[k-1];
            end

            r_top[0] <= n_top;
            r_sh[0]  <= i_mag;

            // Shift the leading one of the largest magnitude up to the window top
            for (int s = 0; s < SHIFT_N; s++) begin
                if ((r_top[s] >> (VEC_W - (SHIFT_MAX >> s))) == '0) begin
                    for (int c = 0; c < UNIT_N; c++) begin
                        r_sh[s+1][c] <= r_sh[s][c] << (SHIFT_MAX >> s);
                    end
                    if (s < SHIFT_N - 1) begin
                        r_top[s+1] <= r_top[s] << (SHIFT_MAX >> s);
                    end
                end else begin
                    r_sh[s+1] <= r_sh[s];
                    if (s < SHIFT_N - 1) begin
                        r_top[s+1] <= r_top[s];
                    end
                end
            end

            for (int c = 0; c < UNIT_N; c++) begin
                r_w[c]  <= r_sh[SHIFT_N][c][VEC_W-1 -: UNIT_W];
                r_sq[c] <= SQ_W'(r_sh[SHIFT_N][c][VEC_W-1 -: UNIT_W])
                         * SQ_W'(r_sh[SHIFT_N][c][VEC_W-1 -: UNIT_W]);
            end

            r_sx[0] <= ACC_W'(r_sq[0]) + ACC_W'(r_sq[1]) + ACC_W'(r_sq[2]) + ACC_W'(r_sq[3]);
            r_sr[0] <= '0;
            r_sw[0] <= r_w;

            for (int s = 0; s < SQRT_N; s++) begin
                if (s < SQRT_N - 1) begin
                    r_sx[s+1] <= n_st[s].x;
                end
                r_sr[s+1] <= n_st[s].r;
                r_sw[s+1] <= r_sw[s];
            end

            // Rounded quotient: (w << frac) + len/2, then divide by len
            for (int c = 0; c < UNIT_N; c++) begin
                r_rem[0][c] <= (DIV_W'(r_sw[SQRT_N][c]) << UNIT_FRAC)
                             + DIV_W'(r_sr[SQRT_N][ROOT_W-1:1]);
            end
            r_dlen[0] <= r_sr[SQRT_N][ROOT_W-1:0];
            r_q[0]    <= '0;

            for (int k = 0; k < DIV_N; k++) begin
                for (int c = 0; c < UNIT_N; c++) begin
                    if (k < DIV_N - 1) begin
                        r_rem[k+1][c] <= n_dv[k][c].rem;
                    end
                    r_q[k+1][c] <= r_q[k][c] | (n_dv[k][c].hit ? (Q_W'(1) << (Q_W - 1 - k))
                                                                : Q_W'(0));
                end
                if (k < DIV_N - 1) begin
                    r_dlen[k+1] <= r_dlen[k];
                end
            end
        end
    end

    always_comb begin
        o_side.valid = r_valid[CORE_LAT-1];
        o_side.tag   = r_tag[CORE_LAT-1];
        for (int c = 0; c < UNIT_N; c++) begin
            o_q[c] = r_zero[CORE_LAT-1] ? Q_W'(0) : r_q[DIV_N][c];
        end
    end

endmodule

`default_nettype wire

// File: rtl/quest_attitude_quaternion.sv
// QUEST attitude quaternion pipeline, top level.
// Depends on qad_pkg and qad_unit_core.
//
// Usage:
//   Slave stream (i_s_axis_*): one item per handshake, twelve signed 16-bit
//   samples: accelerometer, gravity reference, magnetometer and magnetic
//   north reference, x/y/z each.
//   Master stream (o_m_axis_*): one quaternion per item, Q1.14, w first;
//   tuser carries the singular flag (identity given when the Davenport
//   matrix determinant is too small).
//   Configuration: write accel_weight (index 0) and mag_weight (index 1),
//   unsigned Q2.14, through i_cfg_wen/i_cfg_idx/i_cfg_wdata while idle.
// Path from acceptance to o_m_axis_tvalid: the input unit-scaling cores and
//   the output core of 59 stages each (one root bit or one quotient bit per
//   stage), eight attitude stages and the output register.
// Throughput: one item per cycle unless the output stalls; every stage holds one item.
// Reset (synchronous, i_rst_n low): flush all valid bits and restore both
//   weights to 1.0/2 (8192).
// Stall: while a result waits and i_m_axis_tready is low, the whole pipeline
//   holds and o_s_axis_tready drops; nothing is lost or repeated.
`default_nettype none

module quest_attitude_quaternion
    import qad_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port
    input  logic                  i_cfg_wen,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [WEIGHT_W-1:0]   i_cfg_wdata,
    // Input item stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // tdata from bit 0: accel_x, accel_y, accel_z, grav_ref_x, grav_ref_y,
    // grav_ref_z, mag_x, mag_y, mag_z, north_ref_x, north_ref_y, north_ref_z
    input  logic [191:0]          i_s_axis_tdata,
    // Result stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // tdata from bit 0: quat_w, quat_x, quat_y, quat_z
    output logic [63:0]           o_m_axis_tdata,
    // tuser: singular
    output logic [0:0]            o_m_axis_tuser
);

    logic r_out_valid;
    logic n_en;

    logic [WEIGHT_W-1:0] r_wa;
    logic [WEIGHT_W-1:0] r_wm;

    // Advance everything whenever the output register is free or being taken
    assign n_en            = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = n_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wa <= WEIGHT_RESET;
            r_wm <= WEIGHT_RESET;
        end else if (i_cfg_wen) begin
            case (i_cfg_idx)
                REG_ACCEL_WEIGHT: r_wa <= i_cfg_wdata;
                REG_MAG_WEIGHT:   r_wm <= i_cfg_wdata;
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input unit scaling: sign/magnitude split, one core per vector
    // ------------------------------------------------------------------
    t_side                       n_in_side [N_VEC];
    logic [UNIT_N-1:0][VEC_W-1:0] n_in_mag [N_VEC];
    t_side                       w_in_side [N_VEC];
    logic [UNIT_N-1:0][Q_W-1:0]  w_in_q    [N_VEC];

    always_comb begin
        for (int v = 0; v < N_VEC; v++) begin
            n_in_side[v].valid = i_s_axis_tvalid;
            n_in_side[v].tag   = '0;
            n_in_mag[v]        = '0;
            for (int c = 0; c < N_AXIS; c++) begin
                n_in_side[v].tag[c] =
                    i_s_axis_tdata[(N_AXIS * v + c) * SAMPLE_WIDTH + SAMPLE_WIDTH - 1];
                n_in_mag[v][c] = n_in_side[v].tag[c]
                    ? VEC_W'((SAMPLE_WIDTH + 1)'(1) << SAMPLE_WIDTH)
                      - VEC_W'(i_s_axis_tdata[(N_AXIS * v + c) * SAMPLE_WIDTH +: SAMPLE_WIDTH])
                    : VEC_W'(i_s_axis_tdata[(N_AXIS * v + c) * SAMPLE_WIDTH +: SAMPLE_WIDTH]);
            end
        end
    end

    for (genvar v = 0; v < N_VEC; v++) begin : g_in_core
        qad_unit_core u_core (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (n_en),
            .i_side  (n_in_side[v]),
            .i_mag   (n_in_mag[v]),
            .o_side  (w_in_side[v]),
            .o_q     (w_in_q[v])
        );
    end

    // Put the signs back on the unit components
    logic signed [U_W-1:0] n_u [N_VEC][N_AXIS];

    always_comb begin
        for (int v = 0; v < N_VEC; v++) begin
            for (int c = 0; c < N_AXIS; c++) begin
                n_u[v][c] = w_in_side[v].tag[c] ? -$signed(U_W'(w_in_q[v][c]))
                                                :  $signed(U_W'(w_in_q[v][c]));
            end
        end
    end

    // ------------------------------------------------------------------
    // Attitude profile matrix, Davenport matrix, adjugate, determinant
    // ------------------------------------------------------------------
    logic r_v_p, r_v_t, r_v_b, r_v_m, r_v_c, r_v_d1, r_v_d2, r_v_e;

    logic signed [P_W-1:0]  r_pa [N_AXIS][N_AXIS];
    logic signed [P_W-1:0]  r_pm [N_AXIS][N_AXIS];
    logic signed [T_W-1:0]  r_ta [N_AXIS][N_AXIS];
    logic signed [T_W-1:0]  r_tm [N_AXIS][N_AXIS];
    logic signed [B_W-1:0]  r_b  [N_AXIS][N_AXIS];
    logic signed [M_W-1:0]  r_m  [N_AXIS][N_AXIS];
    logic signed [Z_W-1:0]  r_z  [N_AXIS];
    logic signed [C_W-1:0]  r_c  [N_AXIS][N_AXIS];
    logic signed [M_W-1:0]  r_m0 [N_AXIS];
    logic signed [Z_W-1:0]  r_zc [N_AXIS];
    logic signed [PL_W-1:0] r_dlo [N_AXIS];
    logic signed [PL_W-1:0] r_dhi [N_AXIS];
    logic signed [PL_W-1:0] r_nlo [N_AXIS][N_AXIS];
    logic signed [PL_W-1:0] r_nhi [N_AXIS][N_AXIS];
    logic signed [W_W-1:0]  r_det;
    logic signed [W_W-1:0]  r_num [N_AXIS];

    logic signed [T_W:0]    n_bsum [N_AXIS][N_AXIS];
    logic signed [M_W-1:0]  n_alpha;
    logic signed [C_W-1:0]  n_c    [N_AXIS][N_AXIS];
    logic signed [C_W-C_SPLIT-1:0] n_chi [N_AXIS][N_AXIS];
    logic signed [C_SPLIT:0]       n_clo [N_AXIS][N_AXIS];
    logic signed [W_W-1:0]  n_det;
    logic signed [W_W-1:0]  n_num  [N_AXIS];

    always_comb begin
        // Weighted sum rounded to 14 fraction bits: floor(x / 2^28 + 1/2)
        for (int i = 0; i < N_AXIS; i++) begin
            for (int j = 0; j < N_AXIS; j++) begin
                n_bsum[i][j] = (T_W+1)'(r_ta[i][j]) + (T_W+1)'(r_tm[i][j])
                             + $signed((T_W+1)'(1) << (B_SHIFT - 1));
            end
        end

        n_alpha = M_W'($signed({1'b0, r_wa})) + M_W'($signed({1'b0, r_wm}))
                + M_W'(r_b[0][0]) + M_W'(r_b[1][1]) + M_W'(r_b[2][2]);

        n_c[0][0] = C_W'(r_m[1][1] * r_m[2][2]) - C_W'(r_m[1][2] * r_m[2][1]);
        n_c[0][1] = C_W'(r_m[0][2] * r_m[2][1]) - C_W'(r_m[0][1] * r_m[2][2]);
        n_c[0][2] = C_W'(r_m[0][1] * r_m[1][2]) - C_W'(r_m[0][2] * r_m[1][1]);
        n_c[1][0] = C_W'(r_m[1][2] * r_m[2][0]) - C_W'(r_m[1][0] * r_m[2][2]);
        n_c[1][1] = C_W'(r_m[0][0] * r_m[2][2]) - C_W'(r_m[0][2] * r_m[2][0]);
        n_c[1][2] = C_W'(r_m[0][2] * r_m[1][0]) - C_W'(r_m[0][0] * r_m[1][2]);
        n_c[2][0] = C_W'(r_m[1][0] * r_m[2][1]) - C_W'(r_m[1][1] * r_m[2][0]);
        n_c[2][1] = C_W'(r_m[0][1] * r_m[2][0]) - C_W'(r_m[0][0] * r_m[2][1]);
        n_c[2][2] = C_W'(r_m[0][0] * r_m[1][1]) - C_W'(r_m[0][1] * r_m[1][0]);

        // Split each cofactor so the wide products stay within 24 x 22
        for (int i = 0; i < N_AXIS; i++) begin
            for (int j = 0; j < N_AXIS; j++) begin
                n_chi[i][j] = r_c[i][j][C_W-1:C_SPLIT];
                n_clo[i][j] = $signed({1'b0, r_c[i][j][C_SPLIT-1:0]});
            end
        end

        n_det = '0;
        for (int j = 0; j < N_AXIS; j++) begin
            n_det = n_det + (W_W'(r_dhi[j]) <<< C_SPLIT) + W_W'(r_dlo[j]);
        end
        for (int i = 0; i < N_AXIS; i++) begin
            n_num[i] = '0;
            for (int j = 0; j < N_AXIS; j++) begin
                n_num[i] = n_num[i] + (W_W'(r_nhi[i][j]) <<< C_SPLIT) + W_W'(r_nlo[i][j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_p  <= 1'b0;
            r_v_t  <= 1'b0;
            r_v_b  <= 1'b0;
            r_v_m  <= 1'b0;
            r_v_c  <= 1'b0;
            r_v_d1 <= 1'b0;
            r_v_d2 <= 1'b0;
            r_v_e  <= 1'b0;
        end else if (n_en) begin
            r_v_p  <= w_in_side[V_ACC].valid;
            r_v_t  <= r_v_p;
            r_v_b  <= r_v_t;
            r_v_m  <= r_v_b;
            r_v_c  <= r_v_m;
            r_v_d1 <= r_v_c;
            r_v_d2 <= r_v_d1;
            r_v_e  <= r_v_d2;
        end
    end

    // Output-core inputs: |det| and sign-corrected numerator magnitudes
    logic [UNIT_N-1:0][VEC_W-1:0] r_emag;
    logic [TAG_W-1:0]             r_etag;
    logic signed [W_W-1:0]        n_v [N_AXIS];
    logic                         n_sing;

    always_comb begin
        n_sing = (r_det < DET_MIN) && (r_det > -DET_MIN);
        for (int i = 0; i < N_AXIS; i++) begin
            n_v[i] = r_det[W_W-1] ? -r_num[i] : r_num[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            for (int i = 0; i < N_AXIS; i++) begin
                for (int j = 0; j < N_AXIS; j++) begin
                    r_pa[i][j] <= P_W'(n_u[V_ACC][i] * n_u[V_GRAV][j]);
                    r_pm[i][j] <= P_W'(n_u[V_MAG][i] * n_u[V_NORTH][j]);
                    r_ta[i][j] <= T_W'($signed({1'b0, r_wa}) * r_pa[i][j]);
                    r_tm[i][j] <= T_W'($signed({1'b0, r_wm}) * r_pm[i][j]);
                    r_b[i][j]  <= B_W'(n_bsum[i][j] >>> B_SHIFT);
                    r_m[i][j]  <= (i == j ? n_alpha : M_W'(0))
                                - (M_W'(r_b[i][j]) + M_W'(r_b[j][i]));
                    r_c[i][j]  <= n_c[i][j];
                    r_nlo[i][j] <= PL_W'(n_clo[i][j] * r_zc[j]);
                    r_nhi[i][j] <= PL_W'(n_chi[i][j] * r_zc[j]);
                end
                // Carry the first matrix row and z along with the cofactors
                r_m0[i]  <= r_m[0][i];
                r_zc[i]  <= r_z[i];
                r_dlo[i] <= PL_W'(r_m0[i] * n_clo[i][0]);
                r_dhi[i] <= PL_W'(r_m0[i] * n_chi[i][0]);
                r_num[i] <= n_num[i];
            end
            r_z[0] <= Z_W'(r_b[1][2]) - Z_W'(r_b[2][1]);
            r_z[1] <= Z_W'(r_b[2][0]) - Z_W'(r_b[0][2]);
            r_z[2] <= Z_W'(r_b[0][1]) - Z_W'(r_b[1][0]);
            r_det  <= n_det;

            r_emag[0] <= VEC_W'(r_det[W_W-1] ? -r_det : r_det);
            r_etag[0] <= 1'b0;
            for (int i = 0; i < N_AXIS; i++) begin
                r_emag[i+1]  <= VEC_W'(n_v[i][W_W-1] ? -n_v[i] : n_v[i]);
                r_etag[i+1]  <= n_v[i][W_W-1];
            end
            r_etag[TAG_W-1] <= n_sing;
        end
    end

    // ------------------------------------------------------------------
    // Output unit scaling of (|det|, s*nx, s*ny, s*nz)
    // ------------------------------------------------------------------
    t_side                      n_out_side;
    t_side                      w_out_side;
    logic [UNIT_N-1:0][Q_W-1:0] w_out_q;

    assign n_out_side.valid = r_v_e;
    assign n_out_side.tag   = r_etag;

    qad_unit_core u_out_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_side  (n_out_side),
        .i_mag   (r_emag),
        .o_side  (w_out_side),
        .o_q     (w_out_q)
    );

    logic [UNIT_N-1:0][Q_W-1:0] r_quat;
    logic                       r_sing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (n_en) begin
            r_out_valid <= w_out_side.valid;
        end
    end

    // Hold the result until taken; substitute identity on a singular matrix
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_sing <= w_out_side.tag[TAG_W-1];
            for (int c = 0; c < UNIT_N; c++) begin
                if (w_out_side.tag[TAG_W-1]) begin
                    r_quat[c] <= (c == 0) ? (Q_W'(1) << OUT_FRAC_BITS) : Q_W'(0);
                end else begin
                    r_quat[c] <= w_out_side.tag[c] ? -w_out_q[c] : w_out_q[c];
                end
            end
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_quat;
    assign o_m_axis_tuser[0] = r_sing;

endmodule

`default_nettype wire

// File: rtl/qad_check.sv
// Port-level checks for the QUEST attitude pipeline and their bind.
// Depends on quest_attitude_quaternion port names only.
`default_nettype none

module qad_check (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         o_s_axis_tready,
    input wire         o_m_axis_tvalid,
    input wire         i_m_axis_tready,
    input wire [63:0]  o_m_axis_tdata,
    input wire [0:0]   o_m_axis_tuser
);

    // A singular result carries the identity quaternion
    a_sing_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (o_m_axis_tdata == 64'h0000_0000_0000_4000))
        else $error("singular result is not the identity quaternion");

    // The scalar part is never negative
    a_w_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !o_m_axis_tdata[15])
        else $error("negative quaternion scalar part");

    // An empty output register never blocks the input side
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled while no result waits");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind quest_attitude_quaternion qad_check u_qad_check (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire

// File: tb/sv/quest_attitude_checker.sv
// Checker for the QUEST attitude pipeline: watches the config port and both
// streams, predicts each quaternion and compares. Depends on qad_pkg.
module quest_attitude_checker
    import qad_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wen,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [WEIGHT_W-1:0]  i_cfg_wdata,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [191:0]         i_s_tdata,
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [63:0]          i_m_tdata,
    input  logic [0:0]           i_m_tuser,
    output int                   o_errors,
    output int                   o_pending
);
    typedef struct packed {
        logic [15:0] w, x, y, z;
        logic        singular;
    } t_quat;

    logic [WEIGHT_W-1:0] wa_q, wm_q;
    t_quat               quat_q[$];

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Scale n sign-magnitude components to unit length, 14 fraction bits
    function automatic void unit_scale(input longint unsigned mg[4], input bit ng[4],
                                       input int n, output longint res[4]);
        longint unsigned b[4], top, sum, len, v;
        top = 0;
        sum = 0;
        for (int i = 0; i < 4; i++) begin
            res[i] = 0;
            b[i] = (i < n) ? mg[i] : 0;
            if (b[i] > top) top = b[i];
        end
        if (top == 0) return;
        while (top >= (64'd1 << 30)) begin
            top >>= 1;
            for (int i = 0; i < 4; i++) b[i] >>= 1;
        end
        while (top < (64'd1 << 29)) begin
            top <<= 1;
            for (int i = 0; i < 4; i++) b[i] <<= 1;
        end
        for (int i = 0; i < n; i++) sum += b[i] * b[i];
        len = int_sqrt(sum);
        for (int i = 0; i < n; i++) begin
            v = ((b[i] << OUT_FRAC_BITS) + len / 2) / len;
            res[i] = ng[i] ? -longint'(v) : longint'(v);
        end
    endfunction

    function automatic void unit_sample_vec(input logic [47:0] raw, output longint u[3]);
        longint unsigned mg[4];
        bit              ng[4];
        longint          r[4];
        for (int i = 0; i < 4; i++) begin
            mg[i] = 0;
            ng[i] = 0;
        end
        for (int i = 0; i < 3; i++) begin
            ng[i] = raw[16*i+15];
            mg[i] = ng[i] ? 65536 - longint'(raw[16*i +: 16]) : longint'(raw[16*i +: 16]);
        end
        unit_scale(mg, ng, 3, r);
        for (int i = 0; i < 3; i++) u[i] = r[i];
    endfunction

    function automatic t_quat attitude_quat(input logic [191:0] d,
                                            input logic [15:0] wa16, input logic [15:0] wm16);
        longint          a[3], g[3], m[3], nr[3], bm[3][3], dm[3][3], zv[3], c[3][3];
        longint          wa, wm, alpha, det, num[3], q[4];
        longint unsigned qm[4];
        bit              qn[4];
        t_quat           res;
        wa = wa16;
        wm = wm16;
        unit_sample_vec(d[47:0], a);
        unit_sample_vec(d[95:48], g);
        unit_sample_vec(d[143:96], m);
        unit_sample_vec(d[191:144], nr);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                bm[i][j] = (wa * a[i] * g[j] + wm * m[i] * nr[j] + (64'sd1 <<< 27)) >>> 28;
        alpha = wa + wm + bm[0][0] + bm[1][1] + bm[2][2];
        zv[0] = bm[1][2] - bm[2][1];
        zv[1] = bm[2][0] - bm[0][2];
        zv[2] = bm[0][1] - bm[1][0];
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                dm[i][j] = (i == j ? alpha : 0) - (bm[i][j] + bm[j][i]);
        // adjugate
        c[0][0] = dm[1][1] * dm[2][2] - dm[1][2] * dm[2][1];
        c[0][1] = dm[0][2] * dm[2][1] - dm[0][1] * dm[2][2];
        c[0][2] = dm[0][1] * dm[1][2] - dm[0][2] * dm[1][1];
        c[1][0] = dm[1][2] * dm[2][0] - dm[1][0] * dm[2][2];
        c[1][1] = dm[0][0] * dm[2][2] - dm[0][2] * dm[2][0];
        c[1][2] = dm[0][2] * dm[1][0] - dm[0][0] * dm[1][2];
        c[2][0] = dm[1][0] * dm[2][1] - dm[1][1] * dm[2][0];
        c[2][1] = dm[0][1] * dm[2][0] - dm[0][0] * dm[2][1];
        c[2][2] = dm[0][0] * dm[1][1] - dm[0][1] * dm[1][0];
        det = dm[0][0] * c[0][0] + dm[0][1] * c[1][0] + dm[0][2] * c[2][0];
        if (det < longint'(DET_MIN) && det > -longint'(DET_MIN)) begin
            res.w = 16'(1 << OUT_FRAC_BITS);
            res.x = '0;
            res.y = '0;
            res.z = '0;
            res.singular = 1'b1;
            return res;
        end
        for (int i = 0; i < 3; i++)
            num[i] = c[i][0] * zv[0] + c[i][1] * zv[1] + c[i][2] * zv[2];
        qm[0] = det < 0 ? -det : det;
        qn[0] = 0;
        for (int i = 0; i < 3; i++) begin
            longint v;
            v = det < 0 ? -num[i] : num[i];
            qn[i+1] = v < 0;
            qm[i+1] = v < 0 ? -v : v;
        end
        unit_scale(qm, qn, 4, q);
        res.w = q[0][15:0];
        res.x = q[1][15:0];
        res.y = q[2][15:0];
        res.z = q[3][15:0];
        res.singular = 1'b0;
        return res;
    endfunction

    task automatic report(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        wa_q = WEIGHT_RESET;
        wm_q = WEIGHT_RESET;
    end

    assign o_pending = quat_q.size();

    always @(posedge i_clk) begin
        t_quat got, want;
        if (!i_rst_n) begin
            wa_q <= WEIGHT_RESET;
            wm_q <= WEIGHT_RESET;
            quat_q.delete();
        end else begin
            if (i_cfg_wen) begin
                if (i_cfg_idx == REG_ACCEL_WEIGHT) wa_q <= i_cfg_wdata;
                else if (i_cfg_idx == REG_MAG_WEIGHT) wm_q <= i_cfg_wdata;
            end
            if (i_s_tvalid && i_s_tready)
                quat_q.push_back(attitude_quat(i_s_tdata, wa_q, wm_q));
            if (i_m_tvalid && i_m_tready) begin
                got = {i_m_tdata[15:0], i_m_tdata[31:16], i_m_tdata[47:32],
                       i_m_tdata[63:48], i_m_tuser[0]};
                if (quat_q.size() == 0) begin
                    report("result with no expectation");
                end else begin
                    want = quat_q.pop_front();
                    if (got.w != want.w)
                        report($sformatf("quat_w got %0h want %0h", got.w, want.w));
                    if (got.x != want.x)
                        report($sformatf("quat_x got %0h want %0h", got.x, want.x));
                    if (got.y != want.y)
                        report($sformatf("quat_y got %0h want %0h", got.y, want.y));
                    if (got.z != want.z)
                        report($sformatf("quat_z got %0h want %0h", got.z, want.z));
                    if (got.singular != want.singular)
                        report($sformatf("singular got %0b want %0b",
                                         got.singular, want.singular));
                end
            end
        end
    end
endmodule

// File: tb/sv/tb_quest_attitude_quaternion.sv
// Testbench top for the QUEST attitude pipeline: clock, reset, config phases,
// stimulus and back-pressure. Depends on qad_pkg, the DUT and the checker.
module tb_quest_attitude_quaternion;
    import qad_pkg::*;

    localparam int PIPE_LAT = 140;   // longer than the pipeline latency

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_wen;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [WEIGHT_W-1:0]  i_cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [191:0]         s_tdata;     // accel xyz, grav xyz, mag xyz, north xyz from bit 0
    logic                 m_tvalid;
    logic                 m_tready;
    logic [63:0]          m_tdata;     // quat_w, quat_x, quat_y, quat_z from bit 0
    logic [0:0]           m_tuser;     // singular
    int                   n_errors;
    int                   n_pending;
    bit                   stim_done;

    quest_attitude_quaternion u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wen(i_cfg_wen), .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready), .i_s_axis_tdata(s_tdata),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata), .o_m_axis_tuser(m_tuser)
    );

    quest_attitude_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wen(i_cfg_wen), .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .i_m_tuser(m_tuser),
        .o_errors(n_errors), .o_pending(n_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    // Pack four vectors, x/y/z each, accelerometer first
    function automatic logic [191:0] pack_obs(input logic [15:0] v[12]);
        logic [191:0] d;
        for (int k = 0; k < 12; k++) d[16*k +: 16] = v[k];
        return d;
    endfunction

    // Offer one item; hold valid until the handshake, drop it only for a gap
    task automatic send_item(input logic [191:0] d, input bit calm);
        int g;
        g = calm ? 0 : idle_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (n_pending != 0) @(posedge i_clk);
        repeat (PIPE_LAT) @(posedge i_clk);
    endtask

    task automatic write_weights(input logic [15:0] wa, input logic [15:0] wm);
        i_cfg_wen <= 1'b1;
        i_cfg_idx <= REG_ACCEL_WEIGHT;
        i_cfg_wdata <= wa;
        @(posedge i_clk);
        i_cfg_idx <= REG_MAG_WEIGHT;
        i_cfg_wdata <= wm;
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(5))
            0: return 16'($signed($urandom_range(8)) - 4);
            1: return 16'($signed($urandom_range(600)) - 300);
            2: return $urandom_range(1) ? 16'h8000 : 16'h7fff;
            default: return 16'($urandom);
        endcase
    endfunction

    // Random observation set; half pair body to reference (identity or quarter
    // turn about z) so the solve is well conditioned, the rest are pure noise, collinear or have a zero vector
    task automatic random_items(input int n);
        logic [15:0] v[12];
        bit          calm;
        int          zv;
        for (int i = 0; i < n; i++) begin
            calm = (i % 40) < 10;
            for (int k = 0; k < 12; k++) v[k] = rand_sample();
            zv = $urandom_range(3);
            case ($urandom_range(9))
                0: for (int k = 0; k < 3; k++) v[3*zv + k] = '0;
                1: for (int k = 0; k < 3; k++) begin   // collinear observations
                    v[3+k] = v[k];
                    v[6+k] = v[k];
                    v[9+k] = v[k];
                end
                2, 3, 4: for (int k = 0; k < 3; k++) begin   // body equals reference
                    v[3+k] = v[k];
                    v[9+k] = v[6+k];
                end
                5, 6: begin   // quarter turn about z
                    v[3] = -v[1]; v[4] = v[0]; v[5] = v[2];
                    v[9] = -v[7]; v[10] = v[6]; v[11] = v[8];
                end
                default: ;
            endcase
            send_item(pack_obs(v), calm);
        end
    endtask

    task automatic directed_items();
        logic [15:0] v[12];
        logic [15:0] ext[6] = '{16'h7fff, 16'h8000, 16'h0001, 16'hffff, 16'h0000, 16'h4000};
        // all zero vectors
        for (int k = 0; k < 12; k++) v[k] = '0;
        send_item(pack_obs(v), 1);
        // extremes on every field
        for (int e = 0; e < 6; e++) begin
            for (int k = 0; k < 12; k++) v[k] = ext[(e + k) % 6];
            send_item(pack_obs(v), 1);
        end
        for (int k = 0; k < 12; k++) v[k] = 16'h8000;
        send_item(pack_obs(v), 1);
        for (int k = 0; k < 12; k++) v[k] = 16'h7fff;
        send_item(pack_obs(v), 1);
        // identity attitude: a = g along z, m = n along x
        v = '{0, 0, 1000, 0, 0, 1000, 500, 0, 0, 500, 0, 0};
        send_item(pack_obs(v), 1);
        // all four parallel: near-singular matrix
        v = '{0, 0, 100, 0, 0, 100, 0, 0, 100, 0, 0, 100};
        send_item(pack_obs(v), 1);
        // 180 degree turn about z: det sign cases
        v = '{16'hc000, 0, 0, 16'h4000, 0, 0, 0, 16'hc000, 0, 0, 16'h4000, 0};
        send_item(pack_obs(v), 1);
        // one zero vector, others live
        v = '{0, 0, 0, 3, 4, 5, 7, 16'hfff0, 2, 1, 1, 1};
        send_item(pack_obs(v), 0);
        v = '{16'h8000, 16'h7fff, 16'h8000, 1, 16'hffff, 0, 16'h7fff, 0, 0, 0, 16'h7fff, 0};
        send_item(pack_obs(v), 0);
    endtask

    // Receiver: random stalls, with calm stretches
    initial begin
        int g;
        m_tready = 1'b0;
        @(posedge i_clk);
        while (!stim_done || n_pending != 0) begin
            m_tready <= 1'b1;
            repeat ($urandom_range(30, 1)) @(posedge i_clk);
            g = idle_len();
            if (g > 0) begin
                m_tready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
        end
        m_tready <= 1'b1;
    end

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_wen   = 1'b0;
        i_cfg_idx   = REG_ACCEL_WEIGHT;
        i_cfg_wdata = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        stim_done   = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset weights
        directed_items();
        random_items(80);
        drain();
        // both weights at the top of the range
        write_weights(16'hffff, 16'hffff);
        directed_items();
        random_items(70);
        drain();
        // both weights zero: every solve degenerates
        write_weights(16'h0000, 16'h0000);
        random_items(30);
        drain();
        // one observation only
        write_weights(16'h0000, 16'($urandom));
        random_items(60);
        drain();
        write_weights(16'($urandom), 16'h0001);
        random_items(60);
        drain();
        write_weights(16'($urandom), 16'($urandom));
        random_items(90);
        drain();
        stim_done = 1'b1;

        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #20000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
